// ----- rtl/llta_pkg.sv -----
package llta_pkg;

    localparam int unsigned WEIGHT_W = 10;
    localparam int unsigned FACTOR_W = 4;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned TIME_W   = 14;
    localparam int unsigned LOAD_W   = 32;
    localparam int unsigned CHOSEN_W = 4;

    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 88;

    localparam int unsigned CHOSEN_LSB = 0;
    localparam int unsigned TIME_LSB   = CHOSEN_LSB + CHOSEN_W;
    localparam int unsigned LOAD_LSB   = TIME_LSB + TIME_W;
    localparam int unsigned SPAN_LSB   = LOAD_LSB + LOAD_W;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_MACHINE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAVY_FACTOR  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_FACTOR  = 2'd2;

    localparam logic [COUNT_W-1:0]  RST_MACHINE_COUNT = 5'd5;
    localparam logic [FACTOR_W-1:0] RST_HEAVY_FACTOR  = 4'd4;
    localparam logic [FACTOR_W-1:0] RST_LIGHT_FACTOR  = 4'd2;

    typedef struct packed {
        logic [COUNT_W-1:0]  machine_count;
        logic [FACTOR_W-1:0] heavy_factor;
        logic [FACTOR_W-1:0] light_factor;
    } t_cfg;

endpackage

// ----- rtl/llta_cfg.sv -----
module llta_cfg
    import llta_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MACHINE_COUNT: n_cfg.machine_count = i_cfg_data[COUNT_W-1:0];
                CFG_HEAVY_FACTOR:  n_cfg.heavy_factor  = i_cfg_data[FACTOR_W-1:0];
                CFG_LIGHT_FACTOR:  n_cfg.light_factor  = i_cfg_data[FACTOR_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.machine_count <= RST_MACHINE_COUNT;
            r_cfg.heavy_factor  <= RST_HEAVY_FACTOR;
            r_cfg.light_factor  <= RST_LIGHT_FACTOR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/llta_argmin.sv -----
module llta_argmin
    import llta_pkg::*;
#(
    parameter int N  = 16,
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  logic [LOAD_W-1:0] i_load [N],
    input  logic [CW-1:0]     i_active,
    output logic [IW-1:0]     o_index,
    output logic [LOAD_W-1:0] o_load
);

    localparam int LEAVES = 1 << IW;
    localparam int NODES  = 2 * LEAVES - 1;

    logic              w_v  [NODES];
    logic [LOAD_W-1:0] w_ld [NODES];
    logic [IW-1:0]     w_ix [NODES];

    genvar g;
    generate
        for (g = 0; g < LEAVES; g++) begin : g_leaf
            if (g < N) begin : g_used
                assign w_v[LEAVES-1+g]  = (CW'(g) < i_active);
                assign w_ld[LEAVES-1+g] = i_load[g];
            end else begin : g_pad
                assign w_v[LEAVES-1+g]  = 1'b0;
                assign w_ld[LEAVES-1+g] = '0;
            end
            assign w_ix[LEAVES-1+g] = IW'(g);
        end
        for (g = 0; g < LEAVES - 1; g++) begin : g_node
            logic w_take_r;
            assign w_take_r = w_v[2*g+2] && (!w_v[2*g+1] || (w_ld[2*g+2] < w_ld[2*g+1]));
            assign w_v[g]   = w_v[2*g+1] || w_v[2*g+2];
            assign w_ld[g]  = w_take_r ? w_ld[2*g+2] : w_ld[2*g+1];
            assign w_ix[g]  = w_take_r ? w_ix[2*g+2] : w_ix[2*g+1];
        end
    endgenerate

    assign o_index = w_ix[0];
    assign o_load  = w_ld[0];

endmodule

// ----- rtl/least_loaded_task_assigner_core.sv -----
// An accepted request reaches the master side through the input register and the result register.
// One request per cycle unless the master stalls; argmin and add feed table and result regs.
// An input register and the result register decouple the two stream sides.
// Reset is synchronous, active low: clears all loads, the makespan and the valid flags,
// and loads the register defaults (machine_count 5, heavy_factor 4, light_factor 2).
module least_loaded_task_assigner_core
    import llta_pkg::*;
#(
    parameter int MAX_MACHINES = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]   i_s_axis_tdata,  // weight[9:0], zero pad
    input  logic [S_TUSER_W-1:0]   i_s_axis_tuser,  // first_of_batch, heavy_kind
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [M_TDATA_W-1:0]   o_m_axis_tdata,  // chosen_machine, task_time,
                                                    // machine_load, makespan, zero pad
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int CW = $clog2(MAX_MACHINES + 1);

    t_cfg w_cfg;

    llta_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign o_cfg_ready = 1'b1;

    logic                r_in_valid;
    logic                r_first;
    logic                r_heavy;
    logic [WEIGHT_W-1:0] r_weight;
    logic                r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [LOAD_W-1:0]   r_load [MAX_MACHINES];
    logic [LOAD_W-1:0]   r_span;

    logic w_in_acc;
    logic w_adv;

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // active machine count, clamped to 1..MAX_MACHINES
    logic [CW-1:0] w_active;
    always_comb begin
        if (w_cfg.machine_count == '0) begin
            w_active = CW'(1);
        end else if (int'(w_cfg.machine_count) > MAX_MACHINES) begin
            w_active = CW'(MAX_MACHINES);
        end else begin
            w_active = CW'(w_cfg.machine_count);
        end
    end

    logic [LOAD_W-1:0] w_eff [MAX_MACHINES];
    always_comb begin
        for (int i = 0; i < MAX_MACHINES; i++) begin
            w_eff[i] = r_first ? '0 : r_load[i];
        end
    end

    logic [IW-1:0]     w_best;
    logic [LOAD_W-1:0] w_best_load;

    llta_argmin #(
        .N  (MAX_MACHINES),
        .IW (IW),
        .CW (CW)
    ) u_argmin (
        .i_load   (w_eff),
        .i_active (w_active),
        .o_index  (w_best),
        .o_load   (w_best_load)
    );

    logic [FACTOR_W-1:0] w_factor;
    logic [TIME_W-1:0]   w_time;
    logic [LOAD_W:0]     w_sum;
    logic [LOAD_W-1:0]   w_new_load;
    logic [LOAD_W-1:0]   w_span_base;
    logic [LOAD_W-1:0]   w_new_span;

    assign w_factor    = r_heavy ? w_cfg.heavy_factor : w_cfg.light_factor;
    assign w_time      = TIME_W'(r_weight) * TIME_W'(w_factor);
    assign w_sum       = {1'b0, w_best_load} + (LOAD_W+1)'(w_time);
    assign w_new_load  = w_sum[LOAD_W] ? '1 : w_sum[LOAD_W-1:0];
    assign w_span_base = r_first ? '0 : r_span;
    assign w_new_span  = (w_new_load > w_span_base) ? w_new_load : w_span_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_first  <= i_s_axis_tuser[0];
            r_heavy  <= i_s_axis_tuser[1];
            r_weight <= i_s_axis_tdata[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {{(M_TDATA_W-SPAN_LSB-LOAD_W){1'b0}}, w_new_span, w_new_load,
                           w_time, CHOSEN_W'(w_best)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span <= '0;
            for (int i = 0; i < MAX_MACHINES; i++) begin
                r_load[i] <= '0;
            end
        end else if (w_adv) begin
            r_span <= w_new_span;
            for (int i = 0; i < MAX_MACHINES; i++) begin
                if (IW'(i) == w_best) begin
                    r_load[i] <= w_new_load;
                end else if (r_first) begin
                    r_load[i] <= '0;
                end
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/llta_checker.sv -----
module llta_checker
    import llta_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    logic [TIME_W-1:0] w_time;
    logic [LOAD_W-1:0] w_load;
    logic [LOAD_W-1:0] w_span;

    assign w_time = o_m_axis_tdata[TIME_LSB +: TIME_W];
    assign w_load = o_m_axis_tdata[LOAD_LSB +: LOAD_W];
    assign w_span = o_m_axis_tdata[SPAN_LSB +: LOAD_W];

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_span_ge_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> w_span >= w_load)
        else $error("makespan below machine load");

    a_load_ge_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> w_load >= LOAD_W'(w_time))
        else $error("machine load below task time");

endmodule

bind least_loaded_task_assigner_core llta_checker u_llta_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ----- test/least_loaded_task_assigner_core_test.sv -----
`timescale 1ns / 1ps

module least_loaded_task_assigner_core_test;
    import llta_pkg::*;

    localparam int MAX_MACHINES = 16;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 88;
    localparam int PHASES       = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic [CHOSEN_W-1:0] machine;
        logic [TIME_W-1:0]   dur;
        logic [LOAD_W-1:0]   load;
        logic [LOAD_W-1:0]   span;
    } t_assignment;

    typedef struct packed {
        logic                first;
        logic                heavy;
        logic [WEIGHT_W-1:0] weight;
        logic                typed;
        t_assignment         exp;
    } t_directed_row;

    localparam int DIRECTED_N = 14;
    localparam t_directed_row DIRECTED_ROWS [DIRECTED_N] = '{
        '{1'b1, 1'b1, 10'd1023, 1'b1, '{4'd0, 14'd4092, 32'd4092, 32'd4092}},
        '{1'b0, 1'b0, 10'd0,    1'b1, '{4'd1, 14'd0,    32'd0,    32'd4092}},
        '{1'b0, 1'b0, 10'd1023, 1'b1, '{4'd1, 14'd2046, 32'd2046, 32'd4092}},
        '{1'b0, 1'b1, 10'd1,    1'b1, '{4'd2, 14'd4,    32'd4,    32'd4092}},
        '{1'b0, 1'b1, 10'h155,  1'b0, '{4'd0, 14'd0,    32'd0,    32'd0}},
        '{1'b0, 1'b0, 10'h2AA,  1'b0, '{4'd0, 14'd0,    32'd0,    32'd0}},
        '{1'b0, 1'b1, 10'h2AA,  1'b0, '{4'd0, 14'd0,    32'd0,    32'd0}},
        '{1'b0, 1'b0, 10'h155,  1'b0, '{4'd0, 14'd0,    32'd0,    32'd0}},
        '{1'b0, 1'b1, 10'd1023, 1'b0, '{4'd0, 14'd0,    32'd0,    32'd0}},
        '{1'b0, 1'b1, 10'd1023, 1'b0, '{4'd0, 14'd0,    32'd0,    32'd0}},
        '{1'b0, 1'b0, 10'd512,  1'b0, '{4'd0, 14'd0,    32'd0,    32'd0}},
        '{1'b1, 1'b0, 10'd0,    1'b1, '{4'd0, 14'd0,    32'd0,    32'd0}},
        '{1'b0, 1'b1, 10'd1023, 1'b1, '{4'd0, 14'd4092, 32'd4092, 32'd4092}},
        '{1'b0, 1'b1, 10'd1023, 1'b1, '{4'd1, 14'd4092, 32'd4092, 32'd4092}}
    };

    localparam logic [CFG_DATA_W-1:0] PHASE_COUNT [5] = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd17};
    localparam logic [CFG_DATA_W-1:0] PHASE_HEAVY [5] = '{5'd15, 5'h1F, 5'd0, 5'd7, 5'h10};
    localparam logic [CFG_DATA_W-1:0] PHASE_LIGHT [5] = '{5'd0, 5'h11, 5'd15, 5'd9, 5'h1A};

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;
    logic                   o_cfg_ready;

    logic [LOAD_W-1:0]   load_q [MAX_MACHINES];
    logic [LOAD_W-1:0]   span_q = '0;
    logic [COUNT_W-1:0]  count_q = RST_MACHINE_COUNT;
    logic [FACTOR_W-1:0] heavy_q = RST_HEAVY_FACTOR;
    logic [FACTOR_W-1:0] light_q = RST_LIGHT_FACTOR;

    t_assignment pending_assignments [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          idle_on = 1'b1;
    bit          hold_results = 1'b0;

    always #2 i_clk = ~i_clk;

    least_loaded_task_assigner_core #(
        .MAX_MACHINES(MAX_MACHINES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    function automatic t_assignment assign_to_least_loaded(input logic first, input logic heavy,
                                                           input logic [WEIGHT_W-1:0] weight);
        t_assignment         r;
        logic [FACTOR_W-1:0] factor;
        logic [LOAD_W:0]     total;
        int                  active;
        int                  best;
        factor = heavy ? heavy_q : light_q;
        r.dur = TIME_W'(weight) * TIME_W'(factor);
        active = (count_q == 0) ? 1 : (count_q > MAX_MACHINES) ? MAX_MACHINES : int'(count_q);
        if (first) begin
            foreach (load_q[i]) load_q[i] = '0;
            span_q = '0;
        end
        best = 0;
        for (int i = 1; i < active; i++) begin
            if (load_q[i] < load_q[best]) best = i;
        end
        total = {1'b0, load_q[best]} + (LOAD_W+1)'(r.dur);
        load_q[best] = total[LOAD_W] ? '1 : total[LOAD_W-1:0];
        if (load_q[best] > span_q) span_q = load_q[best];
        r.machine = best[CHOSEN_W-1:0];
        r.load = load_q[best];
        r.span = span_q;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [LOAD_W-1:0] want,
                                 input logic [LOAD_W-1:0] got);
        mismatches++;
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_MACHINE_COUNT: count_q = val[COUNT_W-1:0];
            CFG_HEAVY_FACTOR:  heavy_q = val[FACTOR_W-1:0];
            CFG_LIGHT_FACTOR:  light_q = val[FACTOR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] count,
                                  input logic [CFG_DATA_W-1:0] heavy,
                                  input logic [CFG_DATA_W-1:0] light);
        write_reg(CFG_MACHINE_COUNT, count);
        write_reg(CFG_HEAVY_FACTOR, heavy);
        write_reg(CFG_LIGHT_FACTOR, light);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_task(input logic first, input logic heavy,
                             input logic [WEIGHT_W-1:0] weight,
                             input bit typed, input t_assignment typed_exp);
        int          gap;
        t_assignment predicted;
        gap = idle_on ? $urandom_range(14, 0) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W-WEIGHT_W){1'b0}}, weight};
        s_tuser <= {heavy, first};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        predicted = assign_to_least_loaded(first, heavy, weight);
        pending_assignments.insert(pending_assignments.size(), typed ? typed_exp : predicted);
    endtask

    task automatic send_random(input bit allow_first);
        logic [WEIGHT_W-1:0] w;
        case ($urandom_range(7, 0))
            0: w = '0;
            1: w = '1;
            default: w = WEIGHT_W'($urandom_range(1023, 0));
        endcase
        send_task(allow_first && ($urandom_range(19, 0) == 0), 1'($urandom_range(1, 0)), w,
                  1'b0, '0);
    endtask

    task automatic wait_all_assigned();
        while (pending_assignments.size() != 0) @(posedge i_clk);
    endtask

    // result side
    initial begin
        int          gap;
        t_assignment got;
        t_assignment want;
        m_tready <= 1'b1;
        wait (rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = idle_on ? $urandom_range(14, 0) : 0;
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
            got.machine = o_m_axis_tdata[CHOSEN_LSB +: CHOSEN_W];
            got.dur = o_m_axis_tdata[TIME_LSB +: TIME_W];
            got.load = o_m_axis_tdata[LOAD_LSB +: LOAD_W];
            got.span = o_m_axis_tdata[SPAN_LSB +: LOAD_W];
            if (pending_assignments.size() == 0) begin
                flag_mismatch("result with none pending, makespan", '0, got.span);
            end else begin
                want = pending_assignments.pop_front();
                if (got.machine !== want.machine)
                    flag_mismatch("chosen_machine", LOAD_W'(want.machine),
                                  LOAD_W'(got.machine));
                if (got.dur !== want.dur)
                    flag_mismatch("task_time", LOAD_W'(want.dur), LOAD_W'(got.dur));
                if (got.load !== want.load)
                    flag_mismatch("machine_load", want.load, got.load);
                if (got.span !== want.span)
                    flag_mismatch("makespan", want.span, got.span);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready === 1'b1) || (m_tready && o_m_axis_tvalid === 1'b1) ||
            (cfg_valid && o_cfg_ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("least_loaded_task_assigner_core verification failed");
            $finish;
        end
    end

    initial begin
        foreach (load_q[i]) load_q[i] = '0;
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        write_reg(CFG_UNUSED_INDEX, 5'h1F);
        cfg_valid <= 1'b0;

        for (int r = 0; r < DIRECTED_N; r++)
            send_task(DIRECTED_ROWS[r].first, DIRECTED_ROWS[r].heavy, DIRECTED_ROWS[r].weight,
                      DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].exp);
        s_tvalid <= 1'b0;
        wait_all_assigned();

        for (int p = 0; p < PHASES; p++) begin
            if (p < 5)
                write_settings(PHASE_COUNT[p], PHASE_HEAVY[p], PHASE_LIGHT[p]);
            else
                write_settings(5'($urandom_range(31, 0)), 5'($urandom_range(31, 0)),
                               5'($urandom_range(31, 0)));
            idle_on = (p != 4);
            if (p == 2) hold_results = 1'b1;
            // keep loads across the setting change on the first item
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_random(k != 0);
            s_tvalid <= 1'b0;
            wait_all_assigned();
        end

        idle_on = 1'b1;
        write_settings(5'd2, 5'd15, 5'd15);
        for (int k = 0; k < 12; k++)
            send_random(1'b0);
        s_tvalid <= 1'b0;
        wait_all_assigned();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("least_loaded_task_assigner_core verification clean");
        else
            $display("least_loaded_task_assigner_core verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/llta_pkg.sv
rtl/llta_cfg.sv
rtl/llta_argmin.sv
rtl/least_loaded_task_assigner_core.sv
rtl/llta_checker.sv
test/least_loaded_task_assigner_core_test.sv
